@@ rtl/mfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types, constants and decode helpers for the message frame checker.
// ----------------------------------------------------------------------------
package mfc_pkg;

   // Header layout and counter limits
   localparam int unsigned HEADER_BYTES = 8;
   localparam logic [16:0] COUNT_MAX    = 17'h10000;
   localparam logic [15:0] BODY_CLAMP   = 16'hFFFF;

   // Hash constants
   localparam logic [31:0] HASH_MUL = 32'd1664525;
   localparam logic [31:0] HASH_ADD = 32'd1013904223;

   // Code pair for type and subtype decode
   localparam logic [7:0] CODE_A = 8'hF0;
   localparam logic [7:0] CODE_B = 8'h0F;
   localparam logic [3:0] DIST_LIMIT = 4'd4;

   // Decoded pair values
   localparam logic [1:0] PAIR_NONE = 2'd0;
   localparam logic [1:0] PAIR_A    = 2'd1;
   localparam logic [1:0] PAIR_B    = 2'd2;

   // Message kinds
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_CONTROL = 2'd1;
   localparam logic [1:0] KIND_MEDIA   = 2'd2;

   // Check status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_LEN_MISS = 2'd2;
   localparam logic [1:0] STATUS_HASH_MISS = 2'd3;

   // Result kinds
   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // Result queue depth
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // One result transaction
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  check_status;
      logic [1:0]  message_kind;
      logic [7:0]  sub_kind;
      logic [15:0] body_length;
      logic [31:0] sender_address;
      logic [15:0] sender_port;
      logic        end_mark;
   } result_type;

   // Results pushed from the core to the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Number of set bits in a byte
   function automatic logic [3:0] pop_count8(input logic [7:0] value);
      logic [3:0] total;
      total = 4'd0;
      for (int i = 0; i < 8; i++) begin
         total = total + {3'd0, value[i]};
      end
      return total;
   endfunction

   // Nearer code of the pair within distance three, else none
   function automatic logic [1:0] decode_pair(input logic [7:0] code);
      logic [1:0] pair;
      if (pop_count8(code ^ CODE_A) < DIST_LIMIT) begin
         pair = PAIR_A;
      end else if (pop_count8(code ^ CODE_B) < DIST_LIMIT) begin
         pair = PAIR_B;
      end else begin
         pair = PAIR_NONE;
      end
      return pair;
   endfunction

   // Canonical code byte for a decoded pair value
   function automatic logic [7:0] encode_pair(input logic [1:0] pair);
      logic [7:0] code;
      case (pair)
         PAIR_A:  code = CODE_A;
         PAIR_B:  code = CODE_B;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/message_frame_checker.sv @@
// ----------------------------------------------------------------------------
// message_frame_checker
// Byte-serial datagram header check with payload pass-through and summary.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result queue.
// One byte per cycle while the result queue has room; a final payload byte
//   yields two results, which leave the result queue one at a time.
// The hash step for header bytes 0 to 3 is one 32-bit constant multiply and add.
// Reset (synchronous) empties the input register and result queue and clears
//   all datagram state and the held sender fields to zero.
// ----------------------------------------------------------------------------
module message_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   input  logic [31:0] req_source_address,
   input  logic [15:0] req_source_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_check_status,
   output logic [1:0]  rsp_message_kind,
   output logic [7:0]  rsp_sub_kind,
   output logic [15:0] rsp_body_length,
   output logic [31:0] rsp_sender_address,
   output logic [15:0] rsp_sender_port,
   output logic        rsp_end_mark
);
   import mfc_pkg::*;

   push_type   push;
   logic       room;
   result_type head;

   // Parse and check
   mfc_core u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .req_source_address (req_source_address),
      .req_source_port    (req_source_port),
      .room               (room),
      .push               (push)
   );

   // Result queue
   mfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   // Result fields
   assign rsp_result_kind    = head.result_kind;
   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_check_status   = head.check_status;
   assign rsp_message_kind   = head.message_kind;
   assign rsp_sub_kind       = head.sub_kind;
   assign rsp_body_length    = head.body_length;
   assign rsp_sender_address = head.sender_address;
   assign rsp_sender_port    = head.sender_port;
   assign rsp_end_mark       = head.end_mark;

endmodule

@@ rtl/mfc_core.sv @@
// ----------------------------------------------------------------------------
// mfc_core
// Input register and per-byte header parse, hash and summary build.
// ----------------------------------------------------------------------------
module mfc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_final_byte,
   input  logic [31:0]         req_source_address,
   input  logic [15:0]         req_source_port,
   input  logic                room,
   output mfc_pkg::push_type   push
);
   import mfc_pkg::*;

   // Input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_final_ff;
   logic [31:0] in_addr_ff;
   logic [15:0] in_port_ff;

   // Datagram state
   logic [16:0] byte_count_ff, byte_count_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] recv_hash_ff, recv_hash_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  sub_ff, sub_in;
   logic [31:0] held_addr_ff, held_addr_in;
   logic [15:0] held_port_ff, held_port_in;

   logic        advance;
   logic        in_header;
   logic        hash_en;
   logic [7:0]  hash_byte;
   logic [31:0] hash_prod;
   logic [15:0] clamp_count;
   logic [15:0] body;
   logic [1:0]  status;
   logic [1:0]  sum_kind;
   logic [7:0]  sum_sub;
   result_type  payload_res;
   result_type  summary_res;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign in_valid_in = req_valid || (in_valid_ff && !room);

   // Input register load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (!req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
         in_addr_ff  <= req_source_address;
         in_port_ff  <= req_source_port;
      end
   end

   assign in_header = byte_count_ff < 17'(HEADER_BYTES);
   assign hash_prod = hash_ff * HASH_MUL;

   // Header parse and hash step
   always_comb begin
      length_in    = length_ff;
      recv_hash_in = recv_hash_ff;
      kind_in      = kind_ff;
      sub_in       = sub_ff;
      held_addr_in = held_addr_ff;
      held_port_in = held_port_ff;
      hash_en      = 1'b0;
      hash_byte    = in_byte_ff;
      if (byte_count_ff == 17'd0) begin
         held_addr_in = in_addr_ff;
         held_port_in = in_port_ff;
      end
      case (byte_count_ff)
         17'd0, 17'd1: begin
            length_in = {length_ff[7:0], in_byte_ff};
            hash_en   = 1'b1;
         end
         17'd2: begin
            kind_in   = decode_pair(in_byte_ff);
            hash_byte = encode_pair(kind_in);
            hash_en   = 1'b1;
         end
         17'd3: begin
            if (kind_ff == KIND_MEDIA) begin
               sub_in    = {6'd0, decode_pair(in_byte_ff)};
               hash_byte = encode_pair(sub_in[1:0]);
            end else begin
               sub_in = in_byte_ff;
            end
            hash_en = 1'b1;
         end
         17'd4, 17'd5, 17'd6, 17'd7: begin
            recv_hash_in = {recv_hash_ff[23:0], in_byte_ff};
         end
         default: begin
         end
      endcase
      hash_in = hash_en ? (hash_prod + {24'd0, hash_byte} + HASH_ADD) : hash_ff;
      byte_count_in = (byte_count_ff < COUNT_MAX) ? byte_count_ff + 17'd1 : byte_count_ff;
   end

   // Summary status and fields
   always_comb begin
      clamp_count = (byte_count_in > {1'b0, BODY_CLAMP}) ? BODY_CLAMP : byte_count_in[15:0];
      body     = 16'd0;
      sum_kind = KIND_UNKNOWN;
      sum_sub  = 8'd0;
      if (byte_count_in < 17'(HEADER_BYTES)) begin
         status = STATUS_SHORT;
      end else begin
         body = clamp_count - 16'(HEADER_BYTES);
         if ({1'b0, length_in} != byte_count_in) begin
            status = STATUS_LEN_MISS;
         end else begin
            sum_kind = kind_in;
            sum_sub  = sub_in;
            status   = (recv_hash_in == hash_in) ? STATUS_OK : STATUS_HASH_MISS;
         end
      end
   end

   // Result transactions
   always_comb begin
      payload_res = '0;
      payload_res.result_kind  = RESULT_PAYLOAD;
      payload_res.payload_byte = in_byte_ff;

      summary_res = '0;
      summary_res.result_kind     = RESULT_SUMMARY;
      summary_res.check_status    = status;
      summary_res.message_kind    = sum_kind;
      summary_res.sub_kind        = sum_sub;
      summary_res.body_length     = body;
      summary_res.sender_address  = held_addr_in;
      summary_res.sender_port     = held_port_in;
      summary_res.end_mark        = 1'b1;

      push.first  = in_header ? summary_res : payload_res;
      push.second = summary_res;
      if (!advance) begin
         push.count = 2'd0;
      end else begin
         push.count = {1'b0, !in_header} + {1'b0, in_final_ff};
      end
   end

   // State update; a final byte starts a new datagram
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         length_ff     <= '0;
         hash_ff       <= '0;
         recv_hash_ff  <= '0;
         kind_ff       <= KIND_UNKNOWN;
         sub_ff        <= '0;
         held_addr_ff  <= '0;
         held_port_ff  <= '0;
      end else if (advance) begin
         held_addr_ff <= held_addr_in;
         held_port_ff <= held_port_in;
         if (in_final_ff) begin
            byte_count_ff <= '0;
            length_ff     <= '0;
            hash_ff       <= '0;
            recv_hash_ff  <= '0;
            kind_ff       <= KIND_UNKNOWN;
            sub_ff        <= '0;
         end else begin
            byte_count_ff <= byte_count_in;
            length_ff     <= length_in;
            hash_ff       <= hash_in;
            recv_hash_ff  <= recv_hash_in;
            kind_ff       <= kind_in;
            sub_ff        <= sub_in;
         end
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_MAX)
      else $error("byte count beyond saturation");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |=> byte_count_ff == 17'd0)
      else $error("datagram did not restart after final byte");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.result_kind == RESULT_PAYLOAD &&
                             push.second.end_mark)
      else $error("two results not payload then summary");

   a_no_push_stalled: assert property (@(posedge clock) disable iff (reset)
      !room |-> push.count == 2'd0)
      else $error("push without queue room");

endmodule

@@ rtl/mfc_queue.sv @@
// ----------------------------------------------------------------------------
// mfc_queue
// Small result queue: takes up to two results a cycle while it has room, delivers one unless stalled.
// ----------------------------------------------------------------------------
module mfc_queue (
   input  logic                clock,
   input  logic                reset,
   input  mfc_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_stall,
   output mfc_pkg::result_type out_data
);
   import mfc_pkg::*;

   result_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   wr_next;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // Room for a worst-case pair of results
   assign room      = count_ff <= QCNT_W'(QDEPTH - 2);
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   // Pointer and fill count update
   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overfilled");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("fill count moved without traffic");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push while queue lacks room");

endmodule
